// File: rtl/hrr_pkg.sv
// ----------------------------------------------------------------------------
// hrr_pkg
// Types, codes and fixed address map shared by the hex record region router.
// ----------------------------------------------------------------------------
package hrr_pkg;

  typedef enum logic [2:0] {
    PH_COLON = 3'd0,
    PH_LEN   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_LINE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOF   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_BAD_TYPE = 2'd2,
    ERR_FULL     = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    RGN_FLASH = 2'd0,
    RGN_USER  = 2'd1,
    RGN_APP   = 2'd2
  } region_t;

  localparam int SLOT_W   = 11;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int OUT_DW   = 24;

  localparam logic [CFG_AW-1:0] CFG_ADDR_VARIANT = 3'd0;

  localparam logic [16:0] FLASH_BASE_S = 17'h01C00;
  localparam logic [16:0] FLASH_END_S  = 17'h02000;
  localparam logic [16:0] FLASH_BASE_L = 17'h03800;
  localparam logic [16:0] FLASH_END_L  = 17'h04000;
  localparam logic [11:0] FLASH_SIZE_S = 12'd1024;
  localparam logic [11:0] FLASH_SIZE_L = 12'd2048;
  localparam logic [16:0] USER_BASE    = 17'h04200;
  localparam logic [16:0] APP_BASE     = 17'h04340;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_EOF   = 8'h01;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } item_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    region_t           region;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        value;
    err_t              err;
  } result_t;

  // bit 4 = digit valid, bits 3:0 = digit value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: rtl/hrr_apb_regs.sv
// ----------------------------------------------------------------------------
// hrr_apb_regs
// APB register file holding the device variant select.
// ----------------------------------------------------------------------------
module hrr_apb_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hrr_pkg::CFG_AW-1:0] paddr,
  input  logic [hrr_pkg::CFG_DW-1:0] pwdata,
  output logic [hrr_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output logic                      variant
);

  logic variant_r;
  logic variant_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr == hrr_pkg::CFG_ADDR_VARIANT);

  always_comb begin
    variant_nxt = variant_r;
    if (wr_en) begin
      variant_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
    end else begin
      variant_r <= variant_nxt;
    end
  end

  assign prdata  = (paddr == hrr_pkg::CFG_ADDR_VARIANT) ?
                   {{(hrr_pkg::CFG_DW-1){1'b0}}, variant_r} : '0;
  assign variant = variant_r;

endmodule

// File: rtl/hrr_parser.sv
// ----------------------------------------------------------------------------
// hrr_parser
// Record parse state, region decode and region byte counters.
// ----------------------------------------------------------------------------
module hrr_parser #(
  parameter int USER_BYTES = 160,
  parameter int APP_BYTES  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  hrr_pkg::item_t   item,
  input  logic             variant,
  output hrr_pkg::result_t res
);

  localparam int UCW = $clog2(USER_BYTES + 1);
  localparam int ACW = $clog2(APP_BYTES + 1);
  localparam logic [16:0] USER_END = 17'(32'h4200 + 2 * USER_BYTES);
  localparam logic [16:0] APP_END  = 17'(32'h4340 + 2 * APP_BYTES);

  hrr_pkg::phase_t phase_r, phase_nxt, phase_e;
  logic [1:0]      nib_r, nib_nxt, nib_e;
  logic [7:0]      len_r, len_nxt, len_e;
  logic [15:0]     addr_r, addr_nxt, addr_e;
  logic [7:0]      type_r, type_nxt, type_e;
  logic [3:0]      acc_r, acc_nxt, acc_e;
  logic [7:0]      seen_r, seen_nxt, seen_e;
  logic [11:0]     fcnt_r, fcnt_nxt, fcnt_e;
  logic [UCW-1:0]  ucnt_r, ucnt_nxt, ucnt_e;
  logic [ACW-1:0]  acnt_r, acnt_nxt, acnt_e;
  logic            stop_r, stop_nxt, stop_e;

  logic [4:0]  hv;
  logic [3:0]  dig;
  logic [7:0]  byte_v;
  logic [7:0]  type_acc;
  logic [16:0] a17;
  logic [16:0] fbase, fend;
  logic [11:0] fsize;
  logic        in_flash, in_user, in_app;

  assign hv     = hrr_pkg::hex_digit(item.ch);
  assign dig    = hv[3:0];
  assign byte_v = {acc_e, dig};

  assign fbase    = variant ? hrr_pkg::FLASH_BASE_L : hrr_pkg::FLASH_BASE_S;
  assign fend     = variant ? hrr_pkg::FLASH_END_L  : hrr_pkg::FLASH_END_S;
  assign fsize    = variant ? hrr_pkg::FLASH_SIZE_L : hrr_pkg::FLASH_SIZE_S;
  assign a17      = {1'b0, addr_e};
  assign in_flash = (a17 >= fbase) && (a17 < fend);
  assign in_user  = (a17 >= hrr_pkg::USER_BASE) && (a17 < USER_END);
  assign in_app   = (a17 >= hrr_pkg::APP_BASE) && (a17 < APP_END);
  assign type_acc = {type_e[3:0], dig};

  always_comb begin
    phase_e = phase_r;
    nib_e   = nib_r;
    len_e   = len_r;
    addr_e  = addr_r;
    type_e  = type_r;
    acc_e   = acc_r;
    seen_e  = seen_r;
    fcnt_e  = fcnt_r;
    ucnt_e  = ucnt_r;
    acnt_e  = acnt_r;
    stop_e  = stop_r;
    if (item.first) begin
      phase_e = hrr_pkg::PH_COLON;
      nib_e   = '0;
      len_e   = '0;
      addr_e  = '0;
      type_e  = '0;
      acc_e   = '0;
      seen_e  = '0;
      fcnt_e  = '0;
      ucnt_e  = '0;
      acnt_e  = '0;
      stop_e  = 1'b0;
    end
  end

  always_comb begin
    phase_nxt  = phase_e;
    nib_nxt    = nib_e;
    len_nxt    = len_e;
    addr_nxt   = addr_e;
    type_nxt   = type_e;
    acc_nxt    = acc_e;
    seen_nxt   = seen_e;
    fcnt_nxt   = fcnt_e;
    ucnt_nxt   = ucnt_e;
    acnt_nxt   = acnt_e;
    stop_nxt   = stop_e;
    res.valid  = 1'b0;
    res.kind   = hrr_pkg::KIND_DATA;
    res.region = hrr_pkg::RGN_FLASH;
    res.slot   = '0;
    res.value  = '0;
    res.err    = hrr_pkg::ERR_NONE;

    if (!stop_e) begin
      if (phase_e == hrr_pkg::PH_COLON) begin
        if (item.ch != hrr_pkg::CH_COLON) begin
          res.valid = 1'b1;
          res.kind  = hrr_pkg::KIND_ERROR;
          res.err   = hrr_pkg::ERR_BAD_CHAR;
          stop_nxt  = 1'b1;
        end else begin
          phase_nxt = hrr_pkg::PH_LEN;
          nib_nxt   = '0;
          len_nxt   = '0;
          addr_nxt  = '0;
          type_nxt  = '0;
        end
      end else if (phase_e == hrr_pkg::PH_LINE) begin
        if (item.ch == hrr_pkg::CH_NEWLINE) begin
          phase_nxt = hrr_pkg::PH_COLON;
        end
      end else if (!hv[4]) begin
        res.valid = 1'b1;
        res.kind  = hrr_pkg::KIND_ERROR;
        res.err   = hrr_pkg::ERR_BAD_CHAR;
        stop_nxt  = 1'b1;
      end else begin
        unique case (phase_e)
          hrr_pkg::PH_LEN: begin
            len_nxt = {len_e[3:0], dig};
            nib_nxt = nib_e + 2'd1;
            if (nib_e == 2'd1) begin
              phase_nxt = hrr_pkg::PH_ADDR;
              nib_nxt   = '0;
            end
          end
          hrr_pkg::PH_ADDR: begin
            addr_nxt = {addr_e[11:0], dig};
            nib_nxt  = nib_e + 2'd1;
            if (nib_e == 2'd3) begin
              phase_nxt = hrr_pkg::PH_TYPE;
              nib_nxt   = '0;
            end
          end
          hrr_pkg::PH_TYPE: begin
            type_nxt = type_acc;
            nib_nxt  = nib_e + 2'd1;
            if (nib_e == 2'd1) begin
              nib_nxt = '0;
              if (type_acc == hrr_pkg::TYPE_EOF) begin
                res.valid = 1'b1;
                res.kind  = hrr_pkg::KIND_EOF;
                stop_nxt  = 1'b1;
              end else if (type_acc != hrr_pkg::TYPE_DATA) begin
                res.valid = 1'b1;
                res.kind  = hrr_pkg::KIND_ERROR;
                res.err   = hrr_pkg::ERR_BAD_TYPE;
                stop_nxt  = 1'b1;
              end else begin
                seen_nxt  = '0;
                phase_nxt = (len_e == 8'd0) ? hrr_pkg::PH_LINE : hrr_pkg::PH_DATA;
              end
            end
          end
          hrr_pkg::PH_DATA: begin
            if (nib_e == 2'd0) begin
              acc_nxt = dig;
              nib_nxt = 2'd1;
            end else begin
              nib_nxt  = '0;
              seen_nxt = seen_e + 8'd1;
              if (({1'b0, seen_e} + 9'd1) >= {1'b0, len_e}) begin
                phase_nxt = hrr_pkg::PH_LINE;
              end
              priority if (in_flash) begin
                res.valid = 1'b1;
                if (fcnt_e >= fsize) begin
                  res.kind = hrr_pkg::KIND_ERROR;
                  res.err  = hrr_pkg::ERR_FULL;
                  stop_nxt = 1'b1;
                end else begin
                  fcnt_nxt   = fcnt_e + 12'd1;
                  res.region = hrr_pkg::RGN_FLASH;
                  res.slot   = fcnt_e[hrr_pkg::SLOT_W-1:0];
                  res.value  = byte_v;
                end
              end else if (in_user) begin
                if (!seen_e[0]) begin
                  res.valid = 1'b1;
                  if (ucnt_e >= UCW'(USER_BYTES)) begin
                    res.kind = hrr_pkg::KIND_ERROR;
                    res.err  = hrr_pkg::ERR_FULL;
                    stop_nxt = 1'b1;
                  end else begin
                    ucnt_nxt   = ucnt_e + UCW'(1);
                    res.region = hrr_pkg::RGN_USER;
                    res.slot   = hrr_pkg::SLOT_W'(ucnt_e);
                    res.value  = byte_v;
                  end
                end
              end else if (in_app) begin
                if (!seen_e[0]) begin
                  res.valid = 1'b1;
                  if (acnt_e >= ACW'(APP_BYTES)) begin
                    res.kind = hrr_pkg::KIND_ERROR;
                    res.err  = hrr_pkg::ERR_FULL;
                    stop_nxt = 1'b1;
                  end else begin
                    acnt_nxt   = acnt_e + ACW'(1);
                    res.region = hrr_pkg::RGN_APP;
                    res.slot   = hrr_pkg::SLOT_W'(acnt_e);
                    res.value  = byte_v;
                  end
                end
              end else begin
                res.valid = 1'b0;
              end
            end
          end
          default: begin
            phase_nxt = hrr_pkg::PH_COLON;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrr_pkg::PH_COLON;
      nib_r   <= '0;
      len_r   <= '0;
      addr_r  <= '0;
      type_r  <= '0;
      acc_r   <= '0;
      seen_r  <= '0;
      fcnt_r  <= '0;
      ucnt_r  <= '0;
      acnt_r  <= '0;
      stop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      len_r   <= len_nxt;
      addr_r  <= addr_nxt;
      type_r  <= type_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      fcnt_r  <= fcnt_nxt;
      ucnt_r  <= ucnt_nxt;
      acnt_r  <= acnt_nxt;
      stop_r  <= stop_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r && !item.first) |-> !res.valid)
    else $error("result produced while stopped");

  a_user_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ucnt_r <= UCW'(USER_BYTES))
    else $error("user EEPROM count beyond region size");
`endif

endmodule

// File: rtl/hex_record_region_router_unit.sv
// ----------------------------------------------------------------------------
// hex_record_region_router_unit
// Intel HEX text parser that routes data bytes to flash and EEPROM regions.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the output is not stalled and produces
// at most one result per character. An accepted character is registered,
// parsed against the registered record parse state and its result (if any)
// written to the output register. The sustained rate of one character per
// cycle is set by the record parse state, updated as each character is parsed.
// A stalled output holds the parser and then the input register; the input side
// keeps taking characters as long as the input register is free or moving.
module hex_record_region_router_unit #(
  parameter int USER_EEPROM_BYTES = 160,
  parameter int APP_EEPROM_BYTES  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] ch
  input  logic                        in_tuser,   // [0] first
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] region, [12:2] slot, [20:13] value, [22:21] error_code, [23] zero
  output logic [hrr_pkg::OUT_DW-1:0]  out_tdata,
  output logic [1:0]                  out_tuser,  // [1:0] kind
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hrr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [hrr_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [hrr_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  logic             variant;
  logic             in_vld_r, in_vld_nxt;
  hrr_pkg::item_t   in_item_r, in_item_nxt;
  logic             out_vld_r, out_vld_nxt;
  hrr_pkg::result_t out_res_r, out_res_nxt;
  hrr_pkg::result_t res;
  logic             step;
  logic             in_fire;

  hrr_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .variant (variant)
  );

  hrr_parser #(
    .USER_BYTES (USER_EEPROM_BYTES),
    .APP_BYTES  (APP_EEPROM_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (in_item_r),
    .variant (variant),
    .res     (res)
  );

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    if (in_fire) begin
      in_vld_nxt     = 1'b1;
      in_item_nxt.ch    = in_tdata;
      in_item_nxt.first = in_tuser;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (step) begin
      out_vld_nxt = res.valid;
      out_res_nxt = res;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {1'b0, out_res_r.err, out_res_r.value,
                       out_res_r.slot, out_res_r.region};

`ifndef SYNTHESIS
  a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == hrr_pkg::KIND_ERROR) |->
    (out_res_r.err != hrr_pkg::ERR_NONE))
    else $error("error result without error code");

  a_data_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == hrr_pkg::KIND_DATA) |->
    (out_res_r.err == hrr_pkg::ERR_NONE))
    else $error("data result carries an error code");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |-> in_tready)
    else $error("input stage held with empty output register");
`endif

endmodule

// File: verif/hrr_result_checker.sv
// ----------------------------------------------------------------------------
// hrr_result_checker
// Watches the character, result and register ports of the hex record region
// router. Parses every accepted character with its own record parser, keeps
// the routed bytes, end-of-file marks and errors that must come out in order,
// and compares each output transfer with the oldest of them field by field.
// Register readback is checked as well. Counts go back to the testbench top.
// ----------------------------------------------------------------------------
module hrr_result_checker
  import hrr_pkg::*;
#(
  parameter int USER_BYTES = 160,
  parameter int APP_BYTES  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic [1:0]        out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                results_due,
  output int                data_count,
  output int                eof_count,
  output int                error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t             kind;
    region_t           region;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        value;
    err_t              err;
  } routed_t;

  routed_t     routed_q[$];
  bit          variant;
  phase_t      phase;
  logic [2:0]  nibbles;
  logic [7:0]  rec_len;
  logic [7:0]  rec_type;
  logic [15:0] rec_addr;
  logic [7:0]  nib_hold;
  logic [7:0]  byte_index;
  logic [11:0] flash_fill;
  logic [7:0]  user_fill;
  logic [5:0]  app_fill;
  bit          halted;
  int          fails;
  int          n_results;
  int          n_data;
  int          n_eof;
  int          n_err;

  initial begin
    fails = 0;
    n_results = 0;
    n_data = 0;
    n_eof = 0;
    n_err = 0;
  end

  function automatic int digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    phase = PH_COLON;
    nibbles = '0;
    rec_len = '0;
    rec_type = '0;
    rec_addr = '0;
    nib_hold = '0;
    byte_index = '0;
    flash_fill = '0;
    user_fill = '0;
    app_fill = '0;
    halted = 1'b0;
  endtask

  task automatic queue_result(kind_t k, region_t r, logic [SLOT_W-1:0] s, logic [7:0] v,
                              err_t e);
    routed_t x;
    x.kind = k;
    x.region = r;
    x.slot = s;
    x.value = v;
    x.err = e;
    routed_q.push_back(x);
  endtask

  task automatic abort_file(err_t e);
    halted = 1'b1;
    queue_result(KIND_ERROR, RGN_FLASH, '0, '0, e);
  endtask

  task automatic route_byte(logic [7:0] b, logic [7:0] idx);
    int fbase;
    int fsize;
    int a;
    fbase = variant ? int'(FLASH_BASE_L) : int'(FLASH_BASE_S);
    fsize = variant ? int'(FLASH_SIZE_L) : int'(FLASH_SIZE_S);
    a = int'(rec_addr);
    if (a >= fbase && a < fbase + fsize) begin
      if (int'(flash_fill) >= fsize) begin
        abort_file(ERR_FULL);
      end else begin
        queue_result(KIND_DATA, RGN_FLASH, flash_fill[SLOT_W-1:0], b, ERR_NONE);
        flash_fill++;
      end
    end else if (a >= int'(USER_BASE) && a < int'(USER_BASE) + 2 * USER_BYTES) begin
      if (!idx[0]) begin
        if (int'(user_fill) >= USER_BYTES) begin
          abort_file(ERR_FULL);
        end else begin
          queue_result(KIND_DATA, RGN_USER, SLOT_W'(user_fill), b, ERR_NONE);
          user_fill++;
        end
      end
    end else if (a >= int'(APP_BASE) && a < int'(APP_BASE) + 2 * APP_BYTES) begin
      if (!idx[0]) begin
        if (int'(app_fill) >= APP_BYTES) begin
          abort_file(ERR_FULL);
        end else begin
          queue_result(KIND_DATA, RGN_APP, SLOT_W'(app_fill), b, ERR_NONE);
          app_fill++;
        end
      end
    end
  endtask

  task automatic parse_char(logic [7:0] c, logic first);
    int d;
    logic [7:0] b;
    logic [7:0] idx;
    if (first) clear_parse();
    if (halted) return;
    if (phase == PH_COLON) begin
      if (c != CH_COLON) begin
        abort_file(ERR_BAD_CHAR);
      end else begin
        phase = PH_LEN;
        nibbles = '0;
        rec_len = '0;
        rec_addr = '0;
        rec_type = '0;
      end
      return;
    end
    if (phase == PH_LINE) begin
      if (c == CH_NEWLINE) phase = PH_COLON;
      return;
    end
    d = digit_value(c);
    if (d < 0) begin
      abort_file(ERR_BAD_CHAR);
      return;
    end
    case (phase)
      PH_LEN: begin
        rec_len = {rec_len[3:0], d[3:0]};
        nibbles++;
        if (nibbles == 3'd2) begin
          phase = PH_ADDR;
          nibbles = '0;
        end
      end
      PH_ADDR: begin
        rec_addr = {rec_addr[11:0], d[3:0]};
        nibbles++;
        if (nibbles == 3'd4) begin
          phase = PH_TYPE;
          nibbles = '0;
        end
      end
      PH_TYPE: begin
        rec_type = {rec_type[3:0], d[3:0]};
        nibbles++;
        if (nibbles == 3'd2) begin
          nibbles = '0;
          if (rec_type == TYPE_EOF) begin
            halted = 1'b1;
            queue_result(KIND_EOF, RGN_FLASH, '0, '0, ERR_NONE);
          end else if (rec_type != TYPE_DATA) begin
            abort_file(ERR_BAD_TYPE);
          end else begin
            byte_index = '0;
            phase = (rec_len == 8'd0) ? PH_LINE : PH_DATA;
          end
        end
      end
      default: begin
        if (nibbles == 3'd0) begin
          nib_hold = {4'd0, d[3:0]};
          nibbles = 3'd1;
        end else begin
          nibbles = '0;
          b = {nib_hold[3:0], d[3:0]};
          idx = byte_index;
          byte_index++;
          if (int'(idx) + 1 >= int'(rec_len)) phase = PH_LINE;
          route_byte(b, idx);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    fails++;
    if (fails <= 30) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s got %0d expected %0d", n_results, name,
                                got, want));
  endtask

  task automatic check_result();
    routed_t w;
    n_results++;
    if (routed_q.size() == 0) begin
      report_mismatch($sformatf("result %0d (kind %0d) arrived with nothing expected",
                                n_results, out_tuser));
      return;
    end
    w = routed_q.pop_front();
    case (w.kind)
      KIND_DATA: n_data++;
      KIND_EOF:  n_eof++;
      default:   n_err++;
    endcase
    check_field("kind", 16'(out_tuser), 16'(w.kind));
    check_field("region", 16'(out_tdata[1:0]), 16'(w.region));
    check_field("slot", 16'(out_tdata[12:2]), 16'(w.slot));
    check_field("value", 16'(out_tdata[20:13]), 16'(w.value));
    check_field("error_code", 16'(out_tdata[22:21]), 16'(w.err));
    check_field("pad bit", 16'(out_tdata[23]), 16'd0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      variant = 1'b0;
      clear_parse();
      routed_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tuser);
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == CFG_ADDR_VARIANT) begin
        if (cfg_pwrite) begin
          variant = cfg_pwdata[0];
        end else if (cfg_prdata !== CFG_DW'(variant)) begin
          report_mismatch($sformatf("device_variant readback got %0h expected %0h",
                                    cfg_prdata, variant));
        end
      end
    end
    results_due <= routed_q.size();
    mismatch_count <= fails;
    data_count <= n_data;
    eof_count <= n_eof;
    error_count <= n_err;
  end

endmodule

// File: verif/tb_hex_record_region_router_unit.sv
// ----------------------------------------------------------------------------
// tb_hex_record_region_router_unit
// Drives Intel HEX text into the region router one character per transfer:
// a few hand-written files for the special cases, then random files that are
// mostly well-formed records with random lengths, addresses and data, mixed
// with stray characters, bad types, corrupted digits and restarts. A region
// fill runs the application EEPROM into overflow, the device variant is
// switched between phases, and a long output hold backs the block up into
// its input. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hex_record_region_router_unit;
  import hrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int USER_BYTES  = 160;
  localparam int APP_BYTES   = 32;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;     // [7:0] ch
  logic              in_tuser = 1'b0;   // [0] first
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;         // [1:0] region, [12:2] slot, [20:13] value,
                                        // [22:21] error_code, [23] zero
  logic [1:0]        out_tuser;         // [1:0] kind
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int mismatch_count;
  int results_due;
  int data_count;
  int eof_count;
  int error_count;

  logic [8:0] char_q[$];
  bit         variant_now;
  bit         tx_smooth;
  bit         rx_smooth;
  bit         hold_req;
  int         sent_chars;
  int         cfg_writes;

  hex_record_region_router_unit #(
    .USER_EEPROM_BYTES(USER_BYTES),
    .APP_EEPROM_BYTES (APP_BYTES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  hrr_result_checker #(
    .USER_BYTES(USER_BYTES),
    .APP_BYTES (APP_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .mismatch_count(mismatch_count),
    .results_due   (results_due),
    .data_count    (data_count),
    .eof_count     (eof_count),
    .error_count   (error_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(9, 32);
    return $urandom_range(33, 255);
  endfunction

  function automatic logic [15:0] pick_addr();
    int fb;
    int fs;
    int a;
    fb = variant_now ? int'(FLASH_BASE_L) : int'(FLASH_BASE_S);
    fs = variant_now ? int'(FLASH_SIZE_L) : int'(FLASH_SIZE_S);
    case ($urandom_range(0, 7))
      0, 1: a = fb + $urandom_range(0, fs - 1);
      2: a = variant_now ? int'(FLASH_BASE_S) + $urandom_range(0, 1023)
                         : int'(FLASH_BASE_L) + $urandom_range(0, 2047);
      3: a = int'(USER_BASE) + $urandom_range(0, 2 * USER_BYTES - 1);
      4: a = int'(APP_BASE) + $urandom_range(0, 2 * APP_BYTES - 1);
      5: begin
        case ($urandom_range(0, 9))
          0:       a = fb - 1;
          1:       a = fb;
          2:       a = fb + fs - 1;
          3:       a = fb + fs;
          4:       a = int'(USER_BASE) - 1;
          5:       a = int'(USER_BASE);
          6:       a = int'(USER_BASE) + 2 * USER_BYTES - 1;
          7:       a = int'(APP_BASE);
          8:       a = int'(APP_BASE) + 2 * APP_BYTES - 1;
          default: a = int'(APP_BASE) + 2 * APP_BYTES;
        endcase
      end
      default: a = $urandom;
    endcase
    return 16'(a);
  endfunction

  task automatic put_char(logic [7:0] c);
    char_q.push_back({1'b0, c});
  endtask

  task automatic mark_first(int idx);
    logic [8:0] e;
    e = char_q[idx];
    e[8] = 1'b1;
    char_q[idx] = e;
  endtask

  task automatic put_hex8(logic [7:0] b);
    put_char(hex_char(b[7:4]));
    put_char(hex_char(b[3:0]));
  endtask

  task automatic put_record(int len, logic [15:0] addr, logic [7:0] rtype);
    put_char(CH_COLON);
    put_hex8(8'(len));
    put_hex8(addr[15:8]);
    put_hex8(addr[7:0]);
    put_hex8(rtype);
    repeat (len) put_hex8(pick_byte());
    put_hex8(8'($urandom));
    case ($urandom_range(0, 3))
      0: put_char(CH_NEWLINE);
      1: begin
        put_char(8'h0D);
        put_char(CH_NEWLINE);
      end
      2: begin
        repeat ($urandom_range(1, 3)) put_char(8'($urandom));
        put_char(CH_NEWLINE);
      end
      default: begin
        put_char(8'h0D);
        put_char(CH_NEWLINE);
      end
    endcase
  endtask

  task automatic put_eof();
    put_record(0, 16'h0000, TYPE_EOF);
  endtask

  task automatic put_text(string s);
    int start;
    start = char_q.size();
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    mark_first(start);
  endtask

  task automatic put_random_file();
    int start;
    int sel;
    int idx;
    logic [8:0] e;
    start = char_q.size();
    repeat ($urandom_range(1, 5)) begin
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        put_record(pick_len(), pick_addr(), TYPE_DATA);
      end else if (sel < 86) begin
        put_record($urandom_range(0, 4), pick_addr(), 8'($urandom_range(2, 255)));
      end else if (sel < 93) begin
        put_char($urandom_range(0, 1) ? CH_NEWLINE : 8'h0D);
      end else begin
        repeat ($urandom_range(1, 4)) put_char(8'($urandom));
      end
    end
    if ($urandom_range(0, 9) < 7) put_eof();
    if ($urandom_range(0, 99) < 12) begin
      idx = $urandom_range(start, char_q.size() - 1);
      e = char_q[idx];
      e[7:0] = 8'($urandom);
      char_q[idx] = e;
    end
    if ($urandom_range(0, 99) < 5 && char_q.size() > start + 1)
      mark_first($urandom_range(start + 1, char_q.size() - 1));
    mark_first(start);
  endtask

  task automatic send_queued();
    logic [8:0] e;
    int gap;
    while (char_q.size() > 0) begin
      e = char_q.pop_front();
      gap = 0;
      if (!tx_smooth && $urandom_range(0, 99) >= 55) gap = stall_len();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= e[7:0];
      in_tuser <= e[8];
      do @(posedge clk); while (!in_tready);
      sent_chars++;
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_variant(bit v);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_ADDR_VARIANT;
    cfg_pwdata <= CFG_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    variant_now = v;
    cfg_writes++;
  endtask

  task automatic send_fill(logic [16:0] base, int span, int nrec);
    int start;
    start = char_q.size();
    repeat (nrec) put_record(32, 16'(int'(base) + $urandom_range(0, span - 1)), TYPE_DATA);
    put_eof();
    mark_first(start);
    send_queued();
  endtask

  task automatic send_with_hold();
    int start;
    tx_smooth = 1'b1;
    hold_req = 1'b1;
    start = char_q.size();
    put_record(48, variant_now ? 16'(FLASH_BASE_L) : 16'(FLASH_BASE_S), TYPE_DATA);
    put_eof();
    mark_first(start);
    send_queued();
  endtask

  // receiver: random stalls, smooth stretches, one long counted hold
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) rx_smooth = !rx_smooth;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!rx_smooth && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall_left = stall_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #200ms;
    $display("tb_hex_record_region_router_unit: FAIL");
    $finish;
  end

  initial begin
    bit plan[6];
    int target;
    int spins;
    plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_variant(1'b0);

    put_text(":021C0000fF00zz\r\n:00000001FF");
    put_text("Qabc");
    put_text(":0A00000200\n");
    put_text(":0G");
    put_text(":03420000112G");
    put_text(":0343400012345678\n:0000000000\n\r");
    put_text(":02FFFF00ABCD\n:00000001FF");
    send_queued();

    for (int k = 0; k < 6; k++) begin
      write_variant(plan[k]);
      if (k == 0) send_with_hold();
      if (k == 1) send_fill(APP_BASE, 2 * APP_BYTES, APP_BYTES / 16 + 1);
      target = sent_chars + 110;
      while (sent_chars < target) begin
        tx_smooth = ($urandom_range(0, 3) == 0);
        put_random_file();
        send_queued();
      end
    end

    spins = 0;
    while (results_due != 0 && spins < 4000) begin
      @(posedge clk);
      spins++;
    end
    repeat (10) @(posedge clk);
    if (results_due != 0) $display("%0d expected results never arrived", results_due);
    $display("covered %0d characters, %0d register writes across both device variants",
             sent_chars, cfg_writes);
    $display("results: %0d data bytes, %0d end-of-file marks, %0d errors, %0d-cycle hold",
             data_count, eof_count, error_count, HOLD_CYCLES);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb_hex_record_region_router_unit: PASS");
    end else begin
      $display("tb_hex_record_region_router_unit: FAIL");
    end
    $finish;
  end

endmodule
